@@ rtl/bss_pkg.sv @@
// Shared types and constants for the blob steering sequencer.
// Holds the request payload structs, register indexes and phase codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  localparam int unsigned XmW     = 28;
  localparam int unsigned AreaW   = 20;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned ColW    = 10;
  localparam int unsigned FramesW = 8;
  localparam int unsigned CmdW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 20;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MIN_AREA       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_AREA       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BACK_OFF       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_APPROACH_SPEED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPIN_RATE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CENTER_COLUMN  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ALIGN_FRAMES   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HOLD_FRAMES    = 3'd7;

  // Register reset values.
  localparam logic [AreaW-1:0]   MIN_AREA_RST       = 20'd1900;
  localparam logic [AreaW-1:0]   MAX_AREA_RST       = 20'd113000;
  localparam logic [AreaW-1:0]   BACK_OFF_RST       = 20'd20000;
  localparam logic [SpeedW-1:0]  APPROACH_SPEED_RST = 15'd1638;
  localparam logic [SpeedW-1:0]  SPIN_RATE_RST      = 15'd6226;
  localparam logic [ColW-1:0]    CENTER_COLUMN_RST  = 10'd320;
  localparam logic [FramesW-1:0] ALIGN_FRAMES_RST   = 8'd25;
  localparam logic [FramesW-1:0] HOLD_FRAMES_RST    = 8'd4;

  // Phase codes.
  localparam logic [1:0] PH_ALIGN    = 2'd0;
  localparam logic [1:0] PH_APPROACH = 2'd1;
  localparam logic [1:0] PH_DONE     = 2'd2;

  // ceil(2^25 / 25): floor(m * 256 / 25) == (m * RECIP_25) >> 17 for m below 4096.
  localparam logic [20:0] RECIP_25 = 21'd1342178;

  typedef struct packed {
    logic [XmW-1:0]   x_moment;
    logic [AreaW-1:0] pixel_count;
  } in_t;

  typedef struct packed {
    logic signed [CmdW-1:0] linear_speed;
    logic signed [CmdW-1:0] turn_rate;
    logic                   last_of_run;
    logic                   search_done;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/blob_steering_sequencer.sv @@
// A frame request is taken only in the idle state; its commands are offered from the output state.
// The centroid comes from a restoring divider that resolves one quotient bit a cycle,
// followed by the offset, the scaling multiply and the decision states in turn.
// A new frame is not taken until every command of the last one, trailing stop included,
// has been taken at the output, so an output stall holds back the next frame.
// Reset restores all config registers to defaults, the align phase and a zero frame count.
// Top level of the blob steering sequencer; depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blob_steering_sequencer
  import bss_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int unsigned CntW = $clog2(XmW);
  localparam logic [CntW-1:0] DIV_LAST = CntW'(XmW - 1);

  // Configuration registers.
  logic [AreaW-1:0]   min_area_q, max_area_q, back_off_q;
  logic [SpeedW-1:0]  approach_speed_q, spin_rate_q;
  logic [ColW-1:0]    center_column_q;
  logic [FramesW-1:0] align_frames_q, hold_frames_q;

  // Sequencer and datapath registers.
  logic [2:0]         state_q, state_d;
  logic [1:0]         phase_q, phase_d;
  logic [FramesW-1:0] frame_count_q, frame_count_d;
  logic [CntW-1:0]    div_cnt_q, div_cnt_d;
  logic [XmW-1:0]     dvd_q, dvd_d;
  logic [AreaW-1:0]   rem_q, rem_d;
  logic [AreaW-1:0]   pc_q, pc_d;
  logic               neg_q, neg_d;
  logic [11:0]        mag_q, mag_d;
  logic [CmdW-1:0]    qmag_q, qmag_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               stop_pend_q, stop_pend_d;

  // Divider step.
  logic [AreaW:0]     rem_shift, rem_sub;
  logic               div_ge;

  // Offset, scaling and decision.
  logic [XmW-1:0]     centroid, offset;
  logic [32:0]        product;
  logic [CmdW-1:0]    dbl, q1, q2;
  logic [AreaW:0]     hi_area;
  logic [FramesW-1:0] fc_bump, fc_next;
  logic               has_res, stop;
  out_t               res, stop_rec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rem_shift = {rem_q, dvd_q[XmW-1]};
  assign rem_sub   = rem_shift - {1'b0, pc_q};
  assign div_ge    = (rem_shift >= {1'b0, pc_q});

  assign centroid = (pc_q == '0) ? '0 : dvd_q;
  assign offset   = (centroid > XmW'(center_column_q)) ? centroid - XmW'(center_column_q)
                                                       : XmW'(center_column_q) - centroid;
  assign product  = 33'(mag_q) * 33'(RECIP_25);

  // Saturated tracking rate and its doubled form; a positive offset never saturates.
  assign dbl = {qmag_q[CmdW-2:0], 1'b0};
  always_comb begin
    if (!neg_q) begin
      q1 = qmag_q;
      q2 = dbl;
    end else begin
      q1 = (qmag_q > 16'd32768) ? 16'h8000 : ~qmag_q + 16'd1;
      q2 = (qmag_q > 16'd16384) ? 16'h8000 : ~dbl + 16'd1;
    end
  end

  assign hi_area = {1'b0, max_area_q} + {1'b0, back_off_q};
  assign fc_bump = (frame_count_q == '1) ? frame_count_q : frame_count_q + 8'd1;

  always_comb begin
    has_res          = 1'b1;
    fc_next          = frame_count_q;
    res.linear_speed = '0;
    res.turn_rate    = CmdW'(spin_rate_q);
    res.last_of_run  = 1'b0;
    res.search_done  = 1'b0;
    stop             = 1'b0;
    if (phase_q == PH_ALIGN) begin
      if (pc_q > min_area_q) begin
        res.turn_rate = q2;
        fc_next       = fc_bump;
      end
      stop = (fc_next >= align_frames_q);
    end else begin
      priority if (pc_q > min_area_q && pc_q < max_area_q) begin
        res.linear_speed = ~{1'b0, approach_speed_q} + 16'd1;
        res.turn_rate    = q1;
        fc_next          = '0;
      end else if (pc_q >= max_area_q && {1'b0, pc_q} < hi_area) begin
        has_res = 1'b0;
        fc_next = fc_bump;
      end else if ({1'b0, pc_q} >= hi_area) begin
        res.linear_speed = {1'b0, approach_speed_q};
        res.turn_rate    = q1;
      end else begin
        fc_next = '0;
      end
      stop = (fc_next >= hold_frames_q);
    end
    res.last_of_run = !stop;
  end

  assign stop_rec.linear_speed = '0;
  assign stop_rec.turn_rate    = '0;
  assign stop_rec.last_of_run  = 1'b1;
  assign stop_rec.search_done  = (phase_q == PH_APPROACH);

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    frame_count_d = frame_count_q;
    div_cnt_d     = div_cnt_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    pc_d          = pc_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    qmag_d        = qmag_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    stop_pend_d   = stop_pend_q;
    unique case (state_q)
      S_IDLE: begin
        // Frames taken once the search has finished are dropped.
        if (in_valid_i && (phase_q == PH_ALIGN || phase_q == PH_APPROACH)) begin
          dvd_d     = in_data_i.x_moment;
          pc_d      = in_data_i.pixel_count;
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        dvd_d     = {dvd_q[XmW-2:0], div_ge};
        rem_d     = div_ge ? rem_sub[AreaW-1:0] : rem_shift[AreaW-1:0];
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_d   = (centroid > XmW'(center_column_q));
        mag_d   = (offset[XmW-1:12] != '0) ? 12'hFFF : offset[11:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        qmag_d  = product[32:17];
        state_d = S_DEC;
      end
      S_DEC: begin
        frame_count_d = stop ? '0 : fc_next;
        phase_d       = stop ? phase_q + 2'd1 : phase_q;
        if (has_res) begin
          out_d       = res;
          out_valid_d = 1'b1;
          stop_pend_d = stop;
          state_d     = S_OUT;
        end else if (stop) begin
          out_d       = stop_rec;
          out_valid_d = 1'b1;
          stop_pend_d = 1'b0;
          state_d     = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (stop_pend_q) begin
            // The phase has already advanced, so the done flag checks for the done phase.
            out_d.linear_speed = '0;
            out_d.turn_rate    = '0;
            out_d.last_of_run  = 1'b1;
            out_d.search_done  = (phase_q == PH_DONE);
            stop_pend_d        = 1'b0;
          end else begin
            out_valid_d = 1'b0;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_ALIGN;
      frame_count_q <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      stop_pend_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      frame_count_q <= frame_count_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
      stop_pend_q   <= stop_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    pc_q   <= pc_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    qmag_q <= qmag_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q       <= MIN_AREA_RST;
      max_area_q       <= MAX_AREA_RST;
      back_off_q       <= BACK_OFF_RST;
      approach_speed_q <= APPROACH_SPEED_RST;
      spin_rate_q      <= SPIN_RATE_RST;
      center_column_q  <= CENTER_COLUMN_RST;
      align_frames_q   <= ALIGN_FRAMES_RST;
      hold_frames_q    <= HOLD_FRAMES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_AREA:       min_area_q       <= cfg_wdata_i[AreaW-1:0];
        REG_MAX_AREA:       max_area_q       <= cfg_wdata_i[AreaW-1:0];
        REG_BACK_OFF:       back_off_q       <= cfg_wdata_i[AreaW-1:0];
        REG_APPROACH_SPEED: approach_speed_q <= cfg_wdata_i[SpeedW-1:0];
        REG_SPIN_RATE:      spin_rate_q      <= cfg_wdata_i[SpeedW-1:0];
        REG_CENTER_COLUMN:  center_column_q  <= cfg_wdata_i[ColW-1:0];
        REG_ALIGN_FRAMES:   align_frames_q   <= cfg_wdata_i[FramesW-1:0];
        REG_HOLD_FRAMES:    hold_frames_q    <= cfg_wdata_i[FramesW-1:0];
        default: ;
      endcase
    end
  end

  // A result is only ever offered from the output state, never while a frame is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_OUT && !in_ready_o))
    else $error("result offered outside the output state");

  // A trailing stop is only pending behind a result already on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_pend_q |-> out_valid_q && !out_q.last_of_run)
    else $error("pending stop without a leading result");

  // The divider hands over to the offset stage after its last quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == DIV_LAST) |=> state_q == S_DIFF)
    else $error("divider did not finish after its final step");

  // The done flag only rides on a final stop command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.search_done) |->
      (out_q.last_of_run && out_q.turn_rate == '0 && out_q.linear_speed == '0))
    else $error("done flag on a command other than the final stop");

  // Once the last command is taken, the output state releases to idle with nothing on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_ready_i && !stop_pend_q) |=> (state_q == S_IDLE && !out_valid_q))
    else $error("output state did not release after the last command");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the blob steering sequencer: drives frame requests,
// predicts every steering command and checks each one as it leaves the block.
// Depends on bss_pkg and blob_steering_sequencer.
`timescale 1ns / 1ps

module testbench;
  import bss_pkg::*;

  localparam logic [XmW-1:0]   XM_MAX         = '1;
  localparam logic [AreaW-1:0] AREA_MAX       = '1;
  localparam int unsigned      DRAIN_CYCLES   = 48;
  localparam int unsigned      WATCHDOG_LIMIT = 3000;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  // Mirror of the register file and of the sequencing state.
  logic [AreaW-1:0]    cur_min_area       = MIN_AREA_RST;
  logic [AreaW-1:0]    cur_max_area       = MAX_AREA_RST;
  logic [AreaW-1:0]    cur_back_off       = BACK_OFF_RST;
  logic [SpeedW-1:0]   cur_approach_speed = APPROACH_SPEED_RST;
  logic [SpeedW-1:0]   cur_spin_rate      = SPIN_RATE_RST;
  logic [ColW-1:0]     cur_center_col     = CENTER_COLUMN_RST;
  logic [FramesW-1:0]  cur_align_frames   = ALIGN_FRAMES_RST;
  logic [FramesW-1:0]  cur_hold_frames    = HOLD_FRAMES_RST;
  logic [1:0]          trk_phase          = PH_ALIGN;
  logic [FramesW-1:0]  seen_count         = '0;

  out_t                pending_cmds[$];
  int unsigned         mismatches = 0;
  int unsigned         burst_left = 0;

  blob_steering_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Command prediction
  // ---------------------------------------------------------------------------

  function automatic in_t frame(logic [XmW-1:0] xm, logic [AreaW-1:0] pc);
    in_t f;
    f.x_moment    = xm;
    f.pixel_count = pc;
    return f;
  endfunction

  function automatic out_t make_cmd(longint lin, longint turn, logic done);
    out_t c;
    c.linear_speed = lin[CmdW-1:0];
    c.turn_rate    = turn[CmdW-1:0];
    c.last_of_run  = 1'b0;
    c.search_done  = done;
    return c;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Unsaturated tracking rate: (centre - centroid) * 16384 / 1600, truncated toward zero.
  function automatic longint track_rate(in_t f);
    longint cen;
    if (f.pixel_count == 0) cen = 0;
    else cen = f.x_moment / f.pixel_count;
    return ((longint'(cur_center_col) - cen) * 256) / 25;
  endfunction

  function automatic void predict_commands(in_t f);
    out_t        cmds[2];
    int          n;
    int unsigned pc;
    int unsigned top;
    longint      rate;
    n    = 0;
    pc   = f.pixel_count;
    top  = cur_max_area + cur_back_off;
    rate = track_rate(f);
    case (trk_phase)
      PH_ALIGN: begin
        if (pc > cur_min_area) begin
          cmds[n] = make_cmd(0, clip16(2 * rate), 1'b0);
          n++;
          if (seen_count != 8'hFF) seen_count++;
        end else begin
          cmds[n] = make_cmd(0, cur_spin_rate, 1'b0);
          n++;
        end
        if (seen_count >= cur_align_frames) begin
          cmds[n] = make_cmd(0, 0, 1'b0);
          n++;
          seen_count = '0;
          trk_phase  = PH_APPROACH;
        end
      end
      PH_APPROACH: begin
        if (pc > cur_min_area && pc < cur_max_area) begin
          cmds[n] = make_cmd(-longint'(cur_approach_speed), clip16(rate), 1'b0);
          n++;
          seen_count = '0;
        end else if (pc >= cur_max_area && pc < top) begin
          // Inside the hold band the frame is only counted.
          if (seen_count != 8'hFF) seen_count++;
        end else if (pc >= top) begin
          cmds[n] = make_cmd(cur_approach_speed, clip16(rate), 1'b0);
          n++;
        end else begin
          cmds[n] = make_cmd(0, cur_spin_rate, 1'b0);
          n++;
          seen_count = '0;
        end
        if (seen_count >= cur_hold_frames) begin
          cmds[n] = make_cmd(0, 0, 1'b1);
          n++;
          seen_count = '0;
          trk_phase  = PH_DONE;
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      cmds[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_cmds.push_back(cmds[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned band_pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(9, 0))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Up to half of the moments put the centroid on a chosen column, the rest are noise.
  function automatic logic [XmW-1:0] moment_near(int unsigned pc);
    longint m;
    if ($urandom_range(1, 0) == 0) return XmW'($urandom());
    m = longint'(pc) * $urandom_range(1023, 0);
    if (pc != 0) m += $urandom_range(pc - 1, 0);
    if (m > XM_MAX) return XmW'($urandom());
    return m[XmW-1:0];
  endfunction

  function automatic in_t align_frame();
    int unsigned pc;
    // Seen frames are held back near the counter limit so the phase does not end early.
    if (cur_min_area != AREA_MAX && seen_count < 240 && $urandom_range(99, 0) < 60)
      pc = band_pick(cur_min_area + 1, AREA_MAX);
    else
      pc = band_pick(0, cur_min_area);
    return frame(moment_near(pc), AreaW'(pc));
  endfunction

  function automatic in_t approach_frame();
    int unsigned pc;
    int unsigned mn;
    int unsigned mx;
    int unsigned top;
    int unsigned r;
    mn  = cur_min_area;
    mx  = cur_max_area;
    top = mx + cur_back_off;
    pc  = $urandom_range(AREA_MAX, 0);
    r   = $urandom_range(99, 0);
    if (r < 30) begin
      if (mx > mn + 1) pc = band_pick(mn + 1, mx - 1);
    end else if (r < 55) begin
      if (top > mx) pc = band_pick(mx, (top - 1 > AREA_MAX) ? AREA_MAX : top - 1);
    end else if (r < 70) begin
      if (top <= AREA_MAX) pc = band_pick(top, AREA_MAX);
    end else if (r < 90) begin
      pc = band_pick(0, mn);
    end
    if (pc >= mx && pc < top && seen_count >= 200) pc = 0;
    return frame(moment_near(pc), AreaW'(pc));
  endfunction

  task automatic send_frame(in_t f);
    int unsigned gap;
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(99, 0);
      if (r < 3) begin
        burst_left = $urandom_range(30, 10);
        gap = 0;
      end else if (r < 45) begin
        gap = 0;
      end else if (r < 75) begin
        gap = $urandom_range(6, 1);
      end else if (r < 95) begin
        gap = $urandom_range(40, 7);
      end else begin
        gap = $urandom_range(150, 41);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    predict_commands(f);
  endtask

  // Hold frames cause no command, so the block may still be busy once the queue is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MIN_AREA:       cur_min_area       = val;
      REG_MAX_AREA:       cur_max_area       = val;
      REG_BACK_OFF:       cur_back_off       = val;
      REG_APPROACH_SPEED: cur_approach_speed = val[SpeedW-1:0];
      REG_SPIN_RATE:      cur_spin_rate      = val[SpeedW-1:0];
      REG_CENTER_COLUMN:  cur_center_col     = val[ColW-1:0];
      REG_ALIGN_FRAMES:   cur_align_frames   = val[FramesW-1:0];
      REG_HOLD_FRAMES:    cur_hold_frames    = val[FramesW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(int unsigned mn, int unsigned mx, int unsigned bo,
                           int unsigned speed, int unsigned spin, int unsigned col);
    write_reg(REG_MIN_AREA, CfgW'(mn));
    write_reg(REG_MAX_AREA, CfgW'(mx));
    write_reg(REG_BACK_OFF, CfgW'(bo));
    write_reg(REG_APPROACH_SPEED, CfgW'(speed));
    write_reg(REG_SPIN_RATE, CfgW'(spin));
    write_reg(REG_CENTER_COLUMN, CfgW'(col));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: spin below and at the area threshold, steering at the extremes
  // of both fields, a centred blob and truncation of small offsets.
  task automatic test_align_directed();
    send_frame(frame(0, 0));
    send_frame(frame(XM_MAX, MIN_AREA_RST));
    send_frame(frame(0, 1901));
    send_frame(frame(XM_MAX, 1901));
    send_frame(frame(0, AREA_MAX));
    send_frame(frame(XM_MAX, AREA_MAX));
    send_frame(frame(640000, 2000));
    send_frame(frame(641999, 2000));
    send_frame(frame(1901 * 321, 1901));
    send_frame(frame(1901 * 319, 1901));
    send_frame(frame(2, 3));
    send_frame(frame(28'h5555555, 20'hAAAAA));
    send_frame(frame(28'hAAAAAAA, 20'h55555));
    wait_idle();
  endtask

  task automatic test_align_random();
    write_reg(REG_ALIGN_FRAMES, 255);
    load_regs(0, MAX_AREA_RST, BACK_OFF_RST, APPROACH_SPEED_RST, 16384, 1023);
    repeat (100) send_frame(align_frame());
    wait_idle();
    load_regs(AREA_MAX, MAX_AREA_RST, BACK_OFF_RST, APPROACH_SPEED_RST, 0, 0);
    repeat (40) send_frame(align_frame());
    wait_idle();
    load_regs($urandom_range(300000, 0), MAX_AREA_RST, BACK_OFF_RST, APPROACH_SPEED_RST,
              $urandom_range(16384, 0), $urandom_range(1023, 0));
    repeat (100) send_frame(align_frame());
    wait_idle();
  endtask

  // Dropping the threshold to zero part way through ends the phase on the next frame.
  task automatic test_align_exit();
    write_reg(REG_ALIGN_FRAMES, 0);
    send_frame(frame(5000 * 300, 5000));
    wait_idle();
  endtask

  task automatic test_approach_directed();
    load_regs(MIN_AREA_RST, MAX_AREA_RST, BACK_OFF_RST, APPROACH_SPEED_RST,
              SPIN_RATE_RST, CENTER_COLUMN_RST);
    write_reg(REG_HOLD_FRAMES, 255);
    send_frame(frame(0, 0));
    send_frame(frame(XM_MAX, MIN_AREA_RST));
    send_frame(frame(1901 * 320, 1901));
    send_frame(frame(0, 1901));
    send_frame(frame(XM_MAX, 2000));
    send_frame(frame(XM_MAX, 112999));
    send_frame(frame(112999 * 1023, 112999));
    send_frame(frame(113000 * 100, 113000));
    send_frame(frame(132999 * 600, 132999));
    send_frame(frame(0, 133000));
    send_frame(frame(XM_MAX, AREA_MAX));
    wait_idle();
    // With no upper band at all, an empty blob reverses with a centroid of zero.
    write_reg(REG_MAX_AREA, 0);
    write_reg(REG_BACK_OFF, 0);
    send_frame(frame(0, 0));
    send_frame(frame(12345, 0));
    wait_idle();
  endtask

  task automatic test_approach_random();
    int unsigned mn;
    int unsigned mx;
    load_regs(MIN_AREA_RST, MAX_AREA_RST, BACK_OFF_RST, 16384, 16384, 0);
    repeat (70) send_frame(approach_frame());
    wait_idle();
    load_regs(0, AREA_MAX, AREA_MAX, 0, 0, 1023);
    repeat (70) send_frame(approach_frame());
    wait_idle();
    mn = $urandom_range(5000, 0);
    mx = $urandom_range(600000, mn + 2);
    load_regs(mn, mx, 0, $urandom_range(16384, 0), $urandom_range(16384, 0),
              $urandom_range(1023, 0));
    repeat (70) send_frame(approach_frame());
    wait_idle();
    mn = $urandom_range(100000, 0);
    mx = $urandom_range(900000, mn + 2);
    load_regs(mn, mx, $urandom_range(100000, 1), $urandom_range(16384, 0),
              $urandom_range(16384, 0), $urandom_range(1023, 0));
    repeat (70) send_frame(approach_frame());
    wait_idle();
  endtask

  // A reversing frame leaves the hold count alone; the third hold frame finishes.
  task automatic test_approach_exit();
    load_regs(MIN_AREA_RST, MAX_AREA_RST, BACK_OFF_RST, APPROACH_SPEED_RST,
              SPIN_RATE_RST, CENTER_COLUMN_RST);
    send_frame(frame(50000 * 320, 50000));
    wait_idle();
    write_reg(REG_HOLD_FRAMES, 3);
    send_frame(frame(113000 * 300, 113000));
    send_frame(frame(140000 * 350, 140000));
    send_frame(frame(120000 * 310, 120000));
    send_frame(frame(132999 * 330, 132999));
    wait_idle();
  endtask

  task automatic test_done_ignored();
    repeat (5) send_frame(frame(XmW'($urandom()), AreaW'($urandom())));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned r;
    int unsigned len;
    logic        lvl;
    @(posedge clk);
    forever begin
      r = $urandom_range(19, 0);
      if (r == 0) begin
        lvl = 1'b1;
        len = $urandom_range(300, 80);
      end else if (r == 1) begin
        lvl = 1'b0;
        len = $urandom_range(80, 20);
      end else if (r < 6) begin
        lvl = 1'b0;
        len = $urandom_range(12, 4);
      end else if (r < 11) begin
        lvl = 1'b0;
        len = $urandom_range(3, 1);
      end else begin
        lvl = 1'b1;
        len = $urandom_range(16, 1);
      end
      out_ready <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic signed [CmdW-1:0] want,
                                      logic signed [CmdW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: command with none expected, speed %0d turn %0d", $time,
                 out_data.linear_speed, out_data.turn_rate);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("linear_speed", want.linear_speed, out_data.linear_speed);
        check_field("turn_rate", want.turn_rate, out_data.turn_rate);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        check_field("search_done", want.search_done, out_data.search_done);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_align_directed();
    test_align_random();
    test_align_exit();
    test_approach_directed();
    test_approach_random();
    test_approach_exit();
    test_done_ignored();
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
